FILE: hdl/imps_pkg.sv
// Shared constants, codes and types for the I2C motor poll sequencer.
// No dependencies; used by imps_vel_store and i2c_motor_poll_sequencer.
package imps_pkg;

  localparam int MAX_MOTORS = 8;
  localparam int IDX_W = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;
  localparam int SLOT_W = 4;
  localparam int ERR_W = 8;
  localparam int ERR_IDX_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] BASE_ADDR = 8'h52;
  localparam logic [7:0] RESET_TIMEOUT = 8'd50;
  localparam logic [3:0] RESET_COUNT = 4'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_TIMEOUT = 1'd1;

  typedef enum logic [2:0] {
    OP_TRIGGER    = 3'd0,
    OP_START_SENT = 3'd1,
    OP_TX_EMPTY   = 3'd2,
    OP_RX_BYTE    = 3'd3,
    OP_NACK       = 3'd4,
    OP_MS_TICK    = 3'd5,
    OP_SET_VEL    = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_ADDR   = 3'd1,
    CMD_DATA   = 3'd2,
    CMD_START  = 3'd3,
    CMD_STOP   = 3'd4,
    CMD_REINIT = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ACK_KEEP    = 2'd0,
    ACK_ENABLE  = 2'd1,
    ACK_DISABLE = 2'd2
  } ack_t;

  typedef enum logic [1:0] {
    STAGE_ADDR = 2'd0,
    STAGE_DATA = 2'd1,
    STAGE_DONE = 2'd2
  } byte_stage_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } vel_req_t;

endpackage

FILE: hdl/imps_vel_store.sv
// Velocity table: one-write, one-read synchronous memory with registered read data.
// Per-entry valid bits make never-written entries read as zero after reset.
// Depends on imps_pkg.
module imps_vel_store (
  input  logic               clk,
  input  logic               rst,
  input  imps_pkg::vel_req_t req,
  output logic [7:0]         rd_data
);

  logic [7:0]                      mem [imps_pkg::MAX_MOTORS];
  logic [imps_pkg::MAX_MOTORS-1:0] valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= valid[req.rd_addr] ? mem[req.rd_addr] : 8'd0;
    end
  end

endmodule

FILE: hdl/i2c_motor_poll_sequencer.sv
// I2C motor poll sequencer: bus-event driven round control with a velocity memory.
// A result is registered in stage one and then in the output registers before it appears.
// Throughput: one request per cycle unless the output stalls; sequencer state updates
// in the accept cycle and the velocity memory read completes in the following stage.
// Reset clears all round state and the velocity valid bits directly; no clearing pass.
// Depends on imps_pkg and imps_vel_store.
module i2c_motor_poll_sequencer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [imps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [imps_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         op,
  input  logic [7:0]                         rx_data,
  input  logic                               stop_pending,
  input  logic [2:0]                         motor_index,
  input  logic [7:0]                         velocity_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         bus_command,
  output logic [7:0]                         tx_byte,
  output logic [1:0]                         ack_control,
  output logic                               current_valid,
  output logic [2:0]                         current_motor,
  output logic [7:0]                         current_value,
  output logic [7:0]                         error_map,
  output logic                               busy_res
);

  typedef struct packed {
    imps_pkg::cmd_t  cmd;
    logic [7:0]      txb;
    imps_pkg::ack_t  ackc;
    logic            cvalid;
    logic [2:0]      cmotor;
    logic [7:0]      cval;
    logic [7:0]      errmap;
    logic            busy;
    logic            use_mem;
  } res_t;

  // Configuration registers
  logic [3:0] motor_count;
  logic [7:0] round_timeout_ms;

  // Sequencer state
  logic [imps_pkg::ERR_W-1:0]  motor_errors, motor_errors_next;
  logic [imps_pkg::SLOT_W-1:0] current_slot, current_slot_next;
  logic                        reading_phase, reading_phase_next;
  imps_pkg::byte_stage_t       byte_stage, byte_stage_next;
  logic                        round_active, round_active_next;
  logic [7:0]                  timeout_left, timeout_left_next;

  // Pipeline
  logic   s1_valid, s2_valid;
  res_t   s1_res, res_next;
  logic   s1_move, in_fire;
  logic [7:0] rd_data;
  imps_pkg::vel_req_t vel_req;

  logic [3:0]                  eff_count;
  logic [imps_pkg::SLOT_W:0]   adv_sum;
  logic                        adv_done;
  logic                        slot_in_err;
  logic                        slot_in_table;
  logic [imps_pkg::ERR_W-1:0]  slot_bit;
  imps_pkg::op_t               op_code;

  assign s1_move  = s1_valid && (!s2_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;
  assign in_fire  = in_valid && in_ready;
  assign op_code  = imps_pkg::op_t'(op);

  always_comb begin
    if (motor_count == 4'd0) begin
      eff_count = 4'd1;
    end else if (32'(motor_count) > imps_pkg::MAX_MOTORS) begin
      eff_count = 4'(imps_pkg::MAX_MOTORS);
    end else begin
      eff_count = motor_count;
    end
  end

  assign adv_sum       = {1'b0, current_slot} + 5'd1;
  assign adv_done      = adv_sum >= {1'b0, eff_count};
  assign slot_in_err   = 32'(current_slot) < imps_pkg::ERR_W;
  assign slot_in_table = 32'(current_slot) < imps_pkg::MAX_MOTORS;
  assign slot_bit      = slot_in_err ? (8'd1 << current_slot[imps_pkg::ERR_IDX_W-1:0]) : 8'd0;

  always_comb begin
    motor_errors_next  = motor_errors;
    current_slot_next  = current_slot;
    reading_phase_next = reading_phase;
    byte_stage_next    = byte_stage;
    round_active_next  = round_active;
    timeout_left_next  = timeout_left;
    res_next           = '0;
    res_next.cmd       = imps_pkg::CMD_NONE;
    res_next.ackc      = imps_pkg::ACK_KEEP;
    vel_req            = '0;
    unique case (op_code)
      imps_pkg::OP_TRIGGER: begin
        if (!round_active && !stop_pending) begin
          timeout_left_next  = round_timeout_ms;
          current_slot_next  = '0;
          byte_stage_next    = imps_pkg::STAGE_ADDR;
          reading_phase_next = 1'b0;
          round_active_next  = 1'b1;
          res_next.cmd       = imps_pkg::CMD_START;
        end
      end
      imps_pkg::OP_START_SENT: begin
        if (round_active) begin
          res_next.cmd    = imps_pkg::CMD_ADDR;
          res_next.txb    = 8'(imps_pkg::BASE_ADDR + {3'd0, current_slot, 1'b0})
                            | {7'd0, reading_phase};
          res_next.ackc   = imps_pkg::ACK_ENABLE;
          byte_stage_next = imps_pkg::STAGE_ADDR;
        end
      end
      imps_pkg::OP_TX_EMPTY: begin
        if (round_active) begin
          if (byte_stage == imps_pkg::STAGE_ADDR) begin
            motor_errors_next = motor_errors & ~slot_bit;
            if (!reading_phase) begin
              res_next.cmd     = imps_pkg::CMD_DATA;
              res_next.use_mem = slot_in_table;
              vel_req.rd_en    = in_fire && slot_in_table;
              byte_stage_next  = imps_pkg::STAGE_DATA;
            end
          end else begin
            res_next.cmd = imps_pkg::CMD_START;
            if (byte_stage == imps_pkg::STAGE_DATA) begin
              current_slot_next = adv_sum[imps_pkg::SLOT_W-1:0];
              if (adv_done) begin
                current_slot_next  = '0;
                reading_phase_next = 1'b1;
              end
              byte_stage_next = imps_pkg::STAGE_DONE;
            end
          end
        end
      end
      imps_pkg::OP_RX_BYTE: begin
        if (round_active && reading_phase && byte_stage == imps_pkg::STAGE_ADDR) begin
          res_next.cvalid   = 1'b1;
          res_next.cmotor   = current_slot[2:0];
          res_next.cval     = rx_data;
          res_next.ackc     = imps_pkg::ACK_DISABLE;
          current_slot_next = adv_sum[imps_pkg::SLOT_W-1:0];
          if (adv_done) begin
            res_next.cmd      = imps_pkg::CMD_STOP;
            round_active_next = 1'b0;
          end else begin
            res_next.cmd = imps_pkg::CMD_START;
          end
          byte_stage_next = imps_pkg::STAGE_DATA;
        end
      end
      imps_pkg::OP_NACK: begin
        if (round_active) begin
          motor_errors_next = motor_errors | slot_bit;
          current_slot_next = adv_sum[imps_pkg::SLOT_W-1:0];
          res_next.cmd      = imps_pkg::CMD_START;
          if (!reading_phase) begin
            if (adv_done) begin
              current_slot_next  = '0;
              reading_phase_next = 1'b1;
            end
          end else if (adv_done) begin
            res_next.cmd      = imps_pkg::CMD_STOP;
            round_active_next = 1'b0;
          end
        end
      end
      imps_pkg::OP_MS_TICK: begin
        if (round_active) begin
          if (timeout_left != 8'd0) begin
            timeout_left_next = timeout_left - 8'd1;
          end else begin
            round_active_next = 1'b0;
            res_next.cmd      = imps_pkg::CMD_REINIT;
          end
        end
      end
      imps_pkg::OP_SET_VEL: begin
        if (32'(motor_index) < imps_pkg::MAX_MOTORS) begin
          vel_req.wr_en   = in_fire;
          vel_req.wr_addr = imps_pkg::IDX_W'(motor_index);
          vel_req.wr_data = velocity_value;
        end
      end
      default: begin
      end
    endcase
    vel_req.rd_addr = current_slot[imps_pkg::IDX_W-1:0];
    res_next.errmap = motor_errors_next;
    res_next.busy   = round_active_next;
  end

  imps_vel_store u_vel_store (
    .clk     (clk),
    .rst     (rst),
    .req     (vel_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_count      <= imps_pkg::RESET_COUNT;
      round_timeout_ms <= imps_pkg::RESET_TIMEOUT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        imps_pkg::REG_MOTOR_COUNT:   motor_count      <= cfg_data[3:0];
        imps_pkg::REG_ROUND_TIMEOUT: round_timeout_ms <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_errors  <= '0;
      current_slot  <= '0;
      reading_phase <= 1'b0;
      byte_stage    <= imps_pkg::STAGE_ADDR;
      round_active  <= 1'b0;
      timeout_left  <= '0;
    end else if (in_fire) begin
      motor_errors  <= motor_errors_next;
      current_slot  <= current_slot_next;
      reading_phase <= reading_phase_next;
      byte_stage    <= byte_stage_next;
      round_active  <= round_active_next;
      timeout_left  <= timeout_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (out_ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      bus_command   <= s1_res.cmd;
      tx_byte       <= s1_res.use_mem ? rd_data : s1_res.txb;
      ack_control   <= s1_res.ackc;
      current_valid <= s1_res.cvalid;
      current_motor <= s1_res.cmotor;
      current_value <= s1_res.cval;
      error_map     <= s1_res.errmap;
      busy_res      <= s1_res.busy;
    end
  end

  assign out_valid = s2_valid;

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_res))
    else $error("stage one changed while stalled");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && s2_valid && !out_ready)
    else $error("request refused with room in the pipeline");

  a_current_cmd: assert property (@(posedge clk) disable iff (rst)
    out_valid && current_valid |->
      bus_command == imps_pkg::CMD_STOP || bus_command == imps_pkg::CMD_START)
    else $error("current byte without start or stop");

  a_busy_transfer: assert property (@(posedge clk) disable iff (rst)
    out_valid && (bus_command == imps_pkg::CMD_ADDR || bus_command == imps_pkg::CMD_DATA)
      |-> busy_res)
    else $error("bus transfer outside a round");

  a_mem_only_data: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_res.use_mem |-> s1_res.cmd == imps_pkg::CMD_DATA)
    else $error("velocity read for a non-data command");
`endif

endmodule
